// ===== rtl/tsw_pkg.sv =====
// Shared types and constants of the TCP sender window and retransmission engine.
package tsw_pkg;

  localparam int MAX_RESULTS = 64;

  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_EMPTY = 2'd3;

  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_RETX   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] REG_ISN     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAXPAY  = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [10:0] MAXPAY_RESET  = 11'd1000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ack_number;
    logic [15:0] window_advertised;
    logic [15:0] elapsed_ms;
    logic [15:0] bytes_ready;
    logic        input_ended;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seg_seqno;
    logic [10:0] payload_len;
    logic        syn_flag;
    logic        fin_flag;
    logic [31:0] in_flight_bytes;
    logic [7:0]  retx_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] initial_seqno;
    logic [15:0] initial_timeout_ms;
    logic [10:0] max_payload;
    logic        timeout_load;
  } cfg_t;

  typedef struct packed {
    logic [63:0] start;
    logic [10:0] len;
    logic [1:0]  flags;
  } q_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [10:0] len;
    logic        syn;
    logic        fin;
  } res_entry_t;

endpackage

// ===== rtl/tsw_cfg_regs.sv =====
// Configuration registers behind the APB-style port.
module tsw_cfg_regs import tsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [31:0] isn;
  logic [15:0] tmo;
  logic [10:0] maxp;
  logic        wr;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      isn  <= '0;
      tmo  <= TIMEOUT_RESET;
      maxp <= MAXPAY_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_ISN:     isn  <= pwdata;
        REG_TIMEOUT: tmo  <= pwdata[15:0];
        REG_MAXPAY:  maxp <= pwdata[10:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ISN:     prdata = isn;
      REG_TIMEOUT: prdata = {16'd0, tmo};
      REG_MAXPAY:  prdata = {21'd0, maxp};
      default:     prdata = '0;
    endcase
  end

  assign cfg.initial_seqno      = isn;
  assign cfg.initial_timeout_ms = tmo;
  assign cfg.max_payload        = maxp;
  assign cfg.timeout_load       = wr && (paddr[3:2] == REG_TIMEOUT);

endmodule

// ===== rtl/tsw_queue_mem.sv =====
// Retransmission queue memory: one write port, one registered read port.
module tsw_queue_mem import tsw_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  q_entry_t      wdata,
  input  logic [AW-1:0] raddr,
  output q_entry_t      rdata
);

  q_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tsw_result_buf.sv =====
// Buffer for the results of one word while its final status is worked out.
module tsw_result_buf import tsw_pkg::*; (
  input  logic       clk,
  input  logic       we,
  input  logic [5:0] waddr,
  input  res_entry_t wdata,
  input  logic [5:0] raddr,
  output res_entry_t rdata
);

  res_entry_t mem [MAX_RESULTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcp_sender_window_retransmit.sv =====
// TCP sender engine: segment cutting, retransmission queue and timer control.
// A fill cuts each segment in a calc and a send state, an ack pops each queue
// entry in a read-wait and a check state before the fill, and each result then
// leaves through a buffer read, a load and a handshake that waits on out_ready.
// One word is handled at a time; the queue memory read port paces the pops.
// Synchronous reset clears all control state; queue contents are not cleared.
module tcp_sender_window_retransmit import tsw_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
  localparam logic [PW:0]   QD_W = (PW + 1)'(QUEUE_DEPTH);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FILL      = 4'd1;
  localparam logic [3:0] S_FILL_CALC = 4'd2;
  localparam logic [3:0] S_FILL_SEND = 4'd3;
  localparam logic [3:0] S_ACK_UNWR  = 4'd4;
  localparam logic [3:0] S_ACK_CHECK = 4'd5;
  localparam logic [3:0] S_POP_WAIT  = 4'd6;
  localparam logic [3:0] S_POP_CHK   = 4'd7;
  localparam logic [3:0] S_ACK_DONE  = 4'd8;
  localparam logic [3:0] S_TICK      = 4'd9;
  localparam logic [3:0] S_EMPTY     = 4'd10;
  localparam logic [3:0] S_FINISH    = 4'd11;
  localparam logic [3:0] S_DRAIN_RD  = 4'd12;
  localparam logic [3:0] S_DRAIN_LD  = 4'd13;
  localparam logic [3:0] S_DRAIN_OUT = 4'd14;

  cfg_t cfg;

  tsw_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  logic [3:0]    state;
  in_item_t      item;
  logic          from_ack;
  logic [15:0]   avail;
  logic [15:0]   remain;
  logic [63:0]   abs_q;
  logic [6:0]    n_res;
  logic [6:0]    k_out;

  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [63:0]   next_abs;
  logic [63:0]   acked_abs;
  logic [15:0]   window_held;
  logic          window_was_zero;
  logic [31:0]   bytes_out;
  logic [31:0]   timeout_now;
  logic [31:0]   timer_ms;
  logic          timer_running;
  logic [7:0]    retx_run;
  logic          syn_done;
  logic          fin_done;

  q_entry_t      q_wdata, q_rdata;
  logic [PW-1:0] q_waddr;
  logic [PW:0]   slot_sum;
  res_entry_t    r_wdata, r_rdata;
  logic          r_we;

  // Fill datapath.
  logic [15:0] win;
  logic [63:0] used;
  logic [15:0] l1, l2;
  logic        fin_c;

  // Pop check.
  logic [11:0] pop_seqlen;
  logic        pop_stop;

  // Tick datapath.
  logic [32:0] tsum;
  logic [31:0] tm;
  logic        expire;

  // Ack number unwrap against the acknowledged point.
  logic [31:0] off, d_up, d_dn, hi;
  logic [63:0] abs_c;

  // Send and emit controls.
  logic        send;
  logic [10:0] send_len;
  logic        send_syn, send_fin;
  logic [11:0] seqlen;

  assign win = (window_held == 16'd0) ? 16'd1 : window_held;
  assign used = next_abs - acked_abs;
  assign l1 = (remain > {5'd0, cfg.max_payload}) ? {5'd0, cfg.max_payload} : remain;
  assign l2 = (l1 > avail) ? avail : l1;
  assign fin_c = item.input_ended && (avail == l2) && (l2 < win);

  assign pop_seqlen = {1'b0, q_rdata.len} + {11'd0, q_rdata.flags[0]}
                    + {11'd0, q_rdata.flags[1]};
  assign pop_stop = (q_rdata.start + {52'd0, pop_seqlen}) > abs_q;

  assign tsum = {1'b0, timer_ms} + {17'd0, item.elapsed_ms};
  assign tm = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
  assign expire = (tm >= timeout_now) && (count != '0);

  assign off  = item.ack_number - cfg.initial_seqno;
  assign hi   = acked_abs[63:32];
  assign d_up = off - acked_abs[31:0];
  assign d_dn = acked_abs[31:0] - off;
  always_comb begin
    abs_c = {hi, off};
    if (off > acked_abs[31:0] && d_up > 32'h8000_0000 && hi != 32'd0) begin
      abs_c = {hi - 32'd1, off};
    end else if (off < acked_abs[31:0] && d_dn > 32'h8000_0000 && hi != 32'hFFFF_FFFF) begin
      abs_c = {hi + 32'd1, off};
    end
  end

  assign slot_sum = {1'b0, head} + (PW + 1)'(count);
  assign q_waddr = (slot_sum >= QD_W) ? PW'(slot_sum - QD_W) : slot_sum[PW-1:0];

  always_comb begin
    send     = 1'b0;
    send_len = '0;
    send_syn = 1'b0;
    send_fin = 1'b0;
    r_we     = 1'b0;
    r_wdata  = '0;
    case (state)
      S_FILL: begin
        if (!syn_done && count < QD_C) begin
          send     = 1'b1;
          send_syn = 1'b1;
        end
      end
      S_FILL_SEND: begin
        if (remain != 16'd0 && !(l2 == 16'd0 && !fin_c)) begin
          send     = 1'b1;
          send_len = l2[10:0];
          send_fin = fin_c;
        end
      end
      S_TICK: begin
        if (expire) begin
          r_we    = 1'b1;
          r_wdata = '{kind: KIND_RETX,
                      seq: q_rdata.start[31:0] + cfg.initial_seqno,
                      len: q_rdata.len, syn: q_rdata.flags[0], fin: q_rdata.flags[1]};
        end
      end
      S_EMPTY: begin
        r_we    = 1'b1;
        r_wdata = '{kind: KIND_EMPTY, seq: next_abs[31:0] + cfg.initial_seqno,
                    len: 11'd0, syn: 1'b0, fin: 1'b0};
      end
      S_FINISH: begin
        if (n_res == 7'd0) begin
          r_we    = 1'b1;
          r_wdata = '{kind: KIND_STATUS, seq: next_abs[31:0] + cfg.initial_seqno,
                      len: 11'd0, syn: 1'b0, fin: 1'b0};
        end
      end
      default: ;
    endcase
    if (send) begin
      r_we    = 1'b1;
      r_wdata = '{kind: KIND_NEW, seq: next_abs[31:0] + cfg.initial_seqno,
                  len: send_len, syn: send_syn, fin: send_fin};
    end
  end

  assign seqlen  = {1'b0, send_len} + {11'd0, send_syn} + {11'd0, send_fin};
  assign q_wdata = '{start: next_abs, len: send_len, flags: {send_fin, send_syn}};

  tsw_queue_mem #(.DEPTH(QUEUE_DEPTH), .AW(PW)) u_queue (
    .clk, .we(send), .waddr(q_waddr), .wdata(q_wdata), .raddr(head), .rdata(q_rdata)
  );

  tsw_result_buf u_results (
    .clk, .we(r_we), .waddr(n_res[5:0]), .wdata(r_wdata),
    .raddr(k_out[5:0]), .rdata(r_rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      from_ack        <= 1'b0;
      n_res           <= '0;
      k_out           <= '0;
      head            <= '0;
      count           <= '0;
      next_abs        <= '0;
      acked_abs       <= '0;
      window_held     <= 16'd1;
      window_was_zero <= 1'b0;
      bytes_out       <= '0;
      timeout_now     <= {16'd0, TIMEOUT_RESET};
      timer_ms        <= '0;
      timer_running   <= 1'b0;
      retx_run        <= '0;
      syn_done        <= 1'b0;
      fin_done        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.timeout_load) begin
        timeout_now <= {16'd0, pwdata[15:0]};
      end
      if (r_we) begin
        n_res <= n_res + 7'd1;
      end
      if (send) begin
        count     <= count + CW'(1);
        next_abs  <= next_abs + {52'd0, seqlen};
        bytes_out <= bytes_out + {20'd0, seqlen};
        if (!timer_running) begin
          timer_running <= 1'b1;
          timer_ms      <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          n_res <= '0;
          k_out <= '0;
          if (in_valid) begin
            item     <= in_data;
            avail    <= in_data.bytes_ready;
            from_ack <= 1'b0;
            case (in_data.opcode)
              OP_FILL:  state <= S_FILL;
              OP_ACK:   state <= S_ACK_UNWR;
              OP_TICK:  state <= S_TICK;
              default:  state <= S_EMPTY;
            endcase
          end
        end
        S_FILL: begin
          if (!syn_done) begin
            if (send) begin
              syn_done <= 1'b1;
            end
            state <= from_ack ? S_ACK_DONE : S_FINISH;
          end else begin
            window_was_zero <= (window_held == 16'd0);
            state <= S_FILL_CALC;
          end
        end
        S_FILL_CALC: begin
          if (fin_done || count == QD_C || n_res == 7'(MAX_RESULTS)) begin
            state <= from_ack ? S_ACK_DONE : S_FINISH;
          end else begin
            remain <= (used >= {48'd0, win}) ? 16'd0 : win - used[15:0];
            state  <= S_FILL_SEND;
          end
        end
        S_FILL_SEND: begin
          if (send) begin
            avail <= avail - l2;
            if (fin_c) begin
              fin_done <= 1'b1;
            end
            state <= S_FILL_CALC;
          end else begin
            state <= from_ack ? S_ACK_DONE : S_FINISH;
          end
        end
        S_ACK_UNWR: begin
          abs_q    <= abs_c;
          from_ack <= 1'b1;
          state    <= S_ACK_CHECK;
        end
        S_ACK_CHECK: begin
          if (abs_q > next_abs) begin
            state <= S_FINISH;
          end else begin
            window_held <= item.window_advertised;
            if (abs_q <= acked_abs) begin
              state <= S_FINISH;
            end else begin
              acked_abs <= abs_q;
              state     <= S_POP_WAIT;
            end
          end
        end
        S_POP_WAIT: begin
          // The head entry is read here, so its data is ready in the next cycle.
          state <= (count == '0) ? S_FILL : S_POP_CHK;
        end
        S_POP_CHK: begin
          if (pop_stop) begin
            state <= S_FILL;
          end else begin
            bytes_out <= bytes_out - {20'd0, pop_seqlen};
            head      <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
            count     <= count - CW'(1);
            state     <= S_POP_WAIT;
          end
        end
        S_ACK_DONE: begin
          timeout_now <= {16'd0, cfg.initial_timeout_ms};
          retx_run    <= '0;
          if (count != '0) begin
            timer_running <= 1'b1;
            timer_ms      <= '0;
          end
          state <= S_FINISH;
        end
        S_TICK: begin
          if (expire) begin
            if (retx_run != 8'hFF) begin
              retx_run <= retx_run + 8'd1;
            end
            timer_ms <= '0;
            if (!window_was_zero) begin
              timeout_now <= timeout_now[31] ? 32'hFFFF_FFFF : {timeout_now[30:0], 1'b0};
            end
          end else begin
            timer_ms <= tm;
          end
          timer_running <= (count != '0);
          state <= S_FINISH;
        end
        S_EMPTY: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_DRAIN_RD;
        end
        S_DRAIN_RD: begin
          state <= S_DRAIN_LD;
        end
        S_DRAIN_LD: begin
          out_data.kind            <= r_rdata.kind;
          out_data.seg_seqno       <= r_rdata.seq;
          out_data.payload_len     <= r_rdata.len;
          out_data.syn_flag        <= r_rdata.syn;
          out_data.fin_flag        <= r_rdata.fin;
          out_data.in_flight_bytes <= bytes_out;
          out_data.retx_count      <= retx_run;
          out_data.last            <= (k_out + 7'd1 == n_res);
          out_valid                <= 1'b1;
          k_out                    <= k_out + 7'd1;
          state                    <= S_DRAIN_OUT;
        end
        S_DRAIN_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= (k_out == n_res) ? S_IDLE : S_DRAIN_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= QD_C)
    else $error("queue count exceeds the queue depth");

  a_results_bound: assert property (@(posedge clk) disable iff (rst)
      n_res <= 7'(MAX_RESULTS))
    else $error("more results than the result buffer holds");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> state == S_DRAIN_OUT)
    else $error("result shown outside the drain phase");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
      in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_ready && out_data.last |=> state == S_IDLE)
    else $error("engine not idle after the final result");

endmodule

// ===== test/tsw_checker.sv =====
// Predicts the sender's output words from accepted inputs and register writes, and compares.
`timescale 1ns / 1ps
module tsw_checker import tsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output logic [31:0] next_wr,
  output logic [31:0] una_wr,
  output logic [31:0] fly
);

  localparam int QDEPTH = 64;
  localparam longint unsigned SPAN = 64'h1_0000_0000;
  localparam longint unsigned HALF = 64'h8000_0000;

  logic [31:0] isn;
  logic [15:0] rto_init;
  logic [10:0] mss;

  longint unsigned seg_start [QDEPTH];
  logic [10:0]     seg_len   [QDEPTH];
  logic [1:0]      seg_flags [QDEPTH];
  int unsigned     head, count;
  longint unsigned snd_nxt, snd_una;
  int unsigned     wnd_held;
  bit              wnd_zero;
  int unsigned     outstanding, rto, timer_val, retx;
  bit              timer_on, syn_sent, fin_sent;

  res_entry_t  cut_q [$];
  out_item_t   segs_expected [$];

  function automatic logic [31:0] wrap(longint unsigned abs_seq);
    return abs_seq[31:0] + isn;
  endfunction

  function automatic longint unsigned unwrap(logic [31:0] w, longint unsigned chk);
    logic [31:0] off;
    longint unsigned c;
    off = w - isn;
    c = {chk[63:32], off};
    if (c > chk && c - chk > HALF && c >= SPAN)
      c = c - SPAN;
    else if (c < chk && chk - c > HALF && c <= 64'hFFFF_FFFF_FFFF_FFFF - SPAN)
      c = c + SPAN;
    return c;
  endfunction

  function automatic void push_seg(logic [1:0] kind, logic [31:0] seq, logic [10:0] len,
                                   bit syn, bit fin);
    res_entry_t r;
    if (cut_q.size() >= MAX_RESULTS) return;
    r.kind = kind;
    r.seq  = seq;
    r.len  = len;
    r.syn  = syn;
    r.fin  = fin;
    cut_q.push_back(r);
  endfunction

  function automatic void send_seg(int unsigned len, bit syn, bit fin);
    int unsigned slot;
    int unsigned seqlen;
    slot = (head + count) % QDEPTH;
    seqlen = len + syn + fin;
    push_seg(KIND_NEW, wrap(snd_nxt), len[10:0], syn, fin);
    seg_start[slot] = snd_nxt;
    seg_len[slot]   = len[10:0];
    seg_flags[slot] = {fin, syn};
    count++;
    snd_nxt += seqlen;
    outstanding += seqlen;
    if (!timer_on) begin
      timer_on = 1;
      timer_val = 0;
    end
  endfunction

  function automatic void cut_segments(int unsigned avail, bit ended);
    longint unsigned win, used, remain, len;
    bit fin;
    if (!syn_sent) begin
      if (count < QDEPTH && cut_q.size() < MAX_RESULTS) begin
        send_seg(0, 1, 0);
        syn_sent = 1;
      end
      return;
    end
    wnd_zero = (wnd_held == 0);
    win = (wnd_held != 0) ? wnd_held : 1;
    while (!fin_sent && count < QDEPTH && cut_q.size() < MAX_RESULTS) begin
      used = snd_nxt - snd_una;
      remain = (used >= win) ? 0 : win - used;
      fin = 0;
      if (remain == 0) break;
      len = remain;
      if (len > mss) len = mss;
      if (len > avail) len = avail;
      avail -= 32'(len);
      if (ended && avail == 0 && len < win) begin
        fin = 1;
        fin_sent = 1;
      end
      if (len == 0 && !fin) return;
      send_seg(32'(len), 0, fin);
    end
  endfunction

  function automatic void take_ack(logic [31:0] ackw, int unsigned wnd, int unsigned avail,
                                   bit ended);
    longint unsigned abs_ack;
    int unsigned seqlen;
    abs_ack = unwrap(ackw, snd_una);
    if (abs_ack > snd_nxt) return;
    wnd_held = wnd;
    if (abs_ack <= snd_una) return;
    snd_una = abs_ack;
    while (count > 0) begin
      seqlen = seg_len[head] + seg_flags[head][0] + seg_flags[head][1];
      if (seg_start[head] + seqlen > abs_ack) break;
      outstanding -= seqlen;
      head = (head + 1) % QDEPTH;
      count--;
    end
    cut_segments(avail, ended);
    rto = rto_init;
    retx = 0;
    if (count > 0) begin
      timer_on = 1;
      timer_val = 0;
    end
  endfunction

  function automatic void run_timer(int unsigned elapsed);
    longint unsigned t;
    t = longint'(timer_val) + elapsed;
    timer_val = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    if (timer_val >= rto && count > 0) begin
      push_seg(KIND_RETX, wrap(seg_start[head]), seg_len[head], seg_flags[head][0],
               seg_flags[head][1]);
      if (retx < 255) retx++;
      timer_on = 1;
      timer_val = 0;
      if (!wnd_zero)
        rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto * 2;
    end
    if (count == 0) timer_on = 0;
  endfunction

  function automatic void predict_segments(in_item_t it);
    out_item_t e;
    cut_q.delete();
    case (it.opcode)
      OP_FILL:  cut_segments(it.bytes_ready, it.input_ended);
      OP_ACK:   take_ack(it.ack_number, it.window_advertised, it.bytes_ready,
                         it.input_ended);
      OP_TICK:  run_timer(it.elapsed_ms);
      default:  push_seg(KIND_EMPTY, wrap(snd_nxt), 0, 0, 0);
    endcase
    if (cut_q.size() == 0) push_seg(KIND_STATUS, wrap(snd_nxt), 0, 0, 0);
    foreach (cut_q[k]) begin
      e.kind            = cut_q[k].kind;
      e.seg_seqno       = cut_q[k].seq;
      e.payload_len     = cut_q[k].len;
      e.syn_flag        = cut_q[k].syn;
      e.fin_flag        = cut_q[k].fin;
      e.in_flight_bytes = outstanding;
      e.retx_count      = retx[7:0];
      e.last            = (k == cut_q.size() - 1);
      segs_expected.push_back(e);
    end
  endfunction

  function automatic string describe(out_item_t w);
    return $sformatf("kind %0d seq %h len %0d syn %b fin %b fly %0d retx %0d last %b",
                     w.kind, w.seg_seqno, w.payload_len, w.syn_flag, w.fin_flag,
                     w.in_flight_bytes, w.retx_count, w.last);
  endfunction

  function automatic void check_seg(out_item_t got);
    out_item_t e;
    if (segs_expected.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      return;
    end
    e = segs_expected.pop_front();
    if (got.kind !== e.kind || got.seg_seqno !== e.seg_seqno ||
        got.payload_len !== e.payload_len || got.syn_flag !== e.syn_flag ||
        got.fin_flag !== e.fin_flag || got.in_flight_bytes !== e.in_flight_bytes ||
        got.retx_count !== e.retx_count || got.last !== e.last) begin
      errors++;
      $display("%0t: mismatch, expected %s, actual %s", $time, describe(e), describe(got));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      isn = '0;
      rto_init = TIMEOUT_RESET;
      mss = MAXPAY_RESET;
      head = 0;
      count = 0;
      snd_nxt = 0;
      snd_una = 0;
      wnd_held = 1;
      wnd_zero = 0;
      outstanding = 0;
      rto = TIMEOUT_RESET;
      timer_val = 0;
      timer_on = 0;
      retx = 0;
      syn_sent = 0;
      fin_sent = 0;
      errors = 0;
      segs_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ISN:     isn = pwdata;
          REG_TIMEOUT: begin
            rto_init = pwdata[15:0];
            rto = rto_init;
          end
          REG_MAXPAY:  mss = pwdata[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_segments(in_data);
      if (out_valid && out_ready) check_seg(out_data);
    end
    pending = segs_expected.size();
    next_wr = wrap(snd_nxt);
    una_wr = wrap(snd_una);
    fly = snd_nxt[31:0] - snd_una[31:0];
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus, stall generation and final verdict for the TCP sender engine.
`timescale 1ns / 1ps
module testbench;
  import tsw_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          errors, pending;
  logic [31:0] next_wr, una_wr, fly;
  logic        in_took = 1'b0, out_took = 1'b0;
  bit          calm = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tcp_sender_window_retransmit i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tsw_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .next_wr, .una_wr, .fly
  );

  always @(posedge clk) begin
    in_took  <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // The receiver raises ready after each random stall, and a stall of zero length keeps it high.
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_took || out_took || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_word(logic [1:0] op, logic [31:0] ackno, logic [15:0] wnd,
                           logic [15:0] elapsed, logic [15:0] avail, logic ended);
    int g;
    in_item_t it;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    it.opcode = op;
    it.ack_number = ackno;
    it.window_advertised = wnd;
    it.elapsed_ms = elapsed;
    it.bytes_ready = avail;
    it.input_ended = ended;
    in_data <= it;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic random_word(bit may_end);
    int r;
    logic [1:0] op;
    logic [31:0] ackno;
    logic [15:0] wnd, elapsed, avail;
    r = $urandom_range(0, 99);
    op = (r < 35) ? OP_FILL : (r < 70) ? OP_ACK : (r < 90) ? OP_TICK : OP_EMPTY;
    r = $urandom_range(0, 99);
    if (r < 85) ackno = una_wr + $urandom_range(0, fly);
    else ackno = $urandom;
    r = $urandom_range(0, 99);
    wnd = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : (r < 30) ? 16'($urandom)
        : 16'($urandom_range(1, 4000));
    r = $urandom_range(0, 99);
    elapsed = (r < 10) ? 16'hFFFF : (r < 20) ? 16'($urandom)
            : 16'($urandom_range(0, 2000));
    r = $urandom_range(0, 99);
    avail = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : (r < 30) ? 16'($urandom)
          : 16'($urandom_range(1, 3000));
    send_word(op, ackno, wnd, elapsed, avail, may_end && ($urandom_range(0, 2) == 0));
  endtask

  task automatic random_phase(int n, bit ending);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      random_word(ending && i >= n - 30);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: sequence space near the wrap point, tiny segments, short timeout.
    reg_write(REG_ISN, 32'hFFFF_FFFE);
    reg_write(REG_TIMEOUT, 32'd3);
    reg_write(REG_MAXPAY, 32'd4);
    send_word(OP_TICK, 0, 0, 16'd5, 0, 0);
    send_word(OP_EMPTY, 0, 0, 0, 0, 0);
    send_word(OP_ACK, next_wr + 32'd5, 16'd100, 0, 16'd10, 0);
    send_word(OP_FILL, 0, 0, 0, 16'd10, 0);
    send_word(OP_FILL, 0, 0, 0, 16'd10, 0);
    send_word(OP_TICK, 0, 0, 16'hFFFF, 0, 0);
    send_word(OP_ACK, next_wr, 16'd0, 0, 16'd0, 0);
    send_word(OP_FILL, 0, 0, 0, 16'd3, 0);
    send_word(OP_TICK, 0, 0, 16'hFFFF, 0, 0);
    send_word(OP_ACK, una_wr, 16'hFFFF, 0, 0, 0);
    send_word(OP_ACK, una_wr + 32'h8000_0000, 16'd7, 0, 0, 0);
    send_word(OP_FILL, 0, 0, 0, 16'hFFFF, 0);
    send_word(OP_FILL, 0, 0, 0, 16'hFFFF, 0);
    send_word(OP_TICK, 0, 0, 16'd2, 0, 0);
    send_word(OP_ACK, next_wr, 16'hFFFF, 0, 16'hFFFF, 0);
    send_word(OP_EMPTY, 0, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 16'd0, 0, 0);
    send_word(OP_ACK, next_wr, 16'd100, 0, 16'd20, 0);
    send_word(OP_FILL, 0, 0, 0, 16'd20, 0);
    in_valid <= 1'b0;
    settle();

    reg_write(REG_ISN, 32'h0);
    reg_write(REG_TIMEOUT, 32'd1);
    reg_write(REG_MAXPAY, 32'd1452);
    random_phase(100, 0);
    in_valid <= 1'b0;
    settle();

    reg_write(REG_ISN, 32'hFFFF_FFFF);
    reg_write(REG_TIMEOUT, 32'd65535);
    reg_write(REG_MAXPAY, 32'd1);
    random_phase(100, 0);
    in_valid <= 1'b0;
    settle();

    // With no payload allowed only a FIN could be cut.
    reg_write(REG_ISN, $urandom);
    reg_write(REG_TIMEOUT, 32'd40);
    reg_write(REG_MAXPAY, 32'd0);
    random_phase(20, 0);
    in_valid <= 1'b0;
    settle();

    reg_write(REG_ISN, 32'h7FFF_FFFF);
    reg_write(REG_TIMEOUT, 32'd200);
    reg_write(REG_MAXPAY, $urandom_range(1, 1452));
    random_phase(180, 1);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tsw_pkg.sv
rtl/tsw_cfg_regs.sv
rtl/tsw_queue_mem.sv
rtl/tsw_result_buf.sv
rtl/tcp_sender_window_retransmit.sv
test/tsw_checker.sv
test/testbench.sv
